@@ src/ulrs_pkg.sv @@
// ulrs_pkg: types, register indexes and constants shared by the UTF-16
// literal replace / strip core. No dependencies.
`timescale 1ns / 1ps

package ulrs_pkg;

  // Field widths
  localparam int unsigned UNIT_W  = 16;
  localparam int unsigned COUNT_W = 31;
  localparam int unsigned MODE_W  = 8;
  localparam int unsigned PLEN_W  = 8;
  localparam int unsigned CIDX_W  = 8;
  localparam int unsigned CDATA_W = 16;

  // Job queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_MODE        = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] REG_PATTERN_LEN = CIDX_W'(1);
  localparam logic [CIDX_W-1:0] REG_FIRST_UNIT  = CIDX_W'(2);
  localparam logic [CIDX_W-1:0] REG_SECOND_UNIT = CIDX_W'(3);
  localparam logic [CIDX_W-1:0] REG_NEW_UNIT    = CIDX_W'(4);

  // Mode and pattern length codes
  localparam logic [MODE_W-1:0] MODE_LITERAL = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_STRIP   = MODE_W'(2);
  localparam logic [PLEN_W-1:0] PLEN_ONE     = PLEN_W'(1);
  localparam logic [PLEN_W-1:0] PLEN_TWO     = PLEN_W'(2);

  // Control units dropped in strip mode
  localparam logic [UNIT_W-1:0] UNIT_NUL = UNIT_W'(16'h0000);
  localparam logic [UNIT_W-1:0] UNIT_TAB = UNIT_W'(16'h0009);
  localparam logic [UNIT_W-1:0] UNIT_LF  = UNIT_W'(16'h000A);
  localparam logic [UNIT_W-1:0] UNIT_CR  = UNIT_W'(16'h000D);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Configuration register file contents
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PLEN_W-1:0] pattern_length;
    logic [UNIT_W-1:0] first_unit;
    logic [UNIT_W-1:0] second_unit;
    logic [UNIT_W-1:0] new_unit;
  } cfg_t;

  // One classified input word: an optional flushed unit, an optional
  // main unit, and the end-of-string flag.
  typedef struct packed {
    logic [UNIT_W-1:0] flush_unit;
    logic              flush_vld;
    logic [UNIT_W-1:0] main_unit;
    logic              main_vld;
    logic              last;
  } job_t;

endpackage

@@ src/ulrs_intf.sv @@
// Stream and configuration channel interfaces for the UTF-16 literal
// replace / strip core. Depends on ulrs_pkg.
`timescale 1ns / 1ps

// Input channel: one UTF-16 code unit per word
interface ulrs_in_if;
  logic                        valid;
  logic                        ready;
  logic [ulrs_pkg::UNIT_W-1:0] unit_in;
  logic                        last_in;

  modport source (output valid, output unit_in, output last_in, input ready);
  modport sink   (input valid, input unit_in, input last_in, output ready);
endinterface

// Output channel: one result per word
interface ulrs_out_if;
  logic                         valid;
  logic                         ready;
  logic [ulrs_pkg::UNIT_W-1:0]  unit_out;
  logic                         unit_valid;
  logic                         last_out;
  logic [ulrs_pkg::COUNT_W-1:0] kept_count;

  modport source (output valid, output unit_out, output unit_valid, output last_out,
                  output kept_count, input ready);
  modport sink   (input valid, input unit_out, input unit_valid, input last_out,
                  input kept_count, output ready);
endinterface

// Configuration write channel
interface ulrs_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ulrs_pkg::CIDX_W-1:0]  index;
  logic [ulrs_pkg::CDATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/utf16_literal_replace_or_strip_core.sv @@
// Channel   Dir  Payload                                      Handshake
// in_i      in   unit_in[15:0], last_in                       valid/ready
// out_o     out  unit_out[15:0], unit_valid, last_out,        valid/ready
//                kept_count[30:0]
// cfg_i     in   index[7:0], data[15:0]                       valid/ready (ready=1)
//
// One input word per cycle while the job queue is not full; a result word is
// registered in the job queue and then in the output register before it is presented.
// A word that flushes a held first unit and also emits its own unit gives two
// result words from one job; the two-entry job queue can then fill and stall input.
// Input stalls only when the queue is full; output stalls back up through it.
// Reset (rst_ni, async low) clears the held unit, count, queue and registers.
// Depends on ulrs_pkg, ulrs_intf, ulrs_fifo, ulrs_front, ulrs_back.
`timescale 1ns / 1ps

module utf16_literal_replace_or_strip_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  ulrs_in_if.sink    in_i,
  ulrs_out_if.source out_o,
  ulrs_cfg_if.sink   cfg_i
);

  ulrs_pkg::cfg_t cfg_q;
  ulrs_pkg::job_t push_job, head_job;
  logic           push, pop, q_full, q_empty;

  assign cfg_i.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode           <= '0;
      cfg_q.pattern_length <= ulrs_pkg::PLEN_ONE;
      cfg_q.first_unit     <= '0;
      cfg_q.second_unit    <= '0;
      cfg_q.new_unit       <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        ulrs_pkg::REG_MODE:
          cfg_q.mode <= cfg_i.data[ulrs_pkg::MODE_W-1:0];
        ulrs_pkg::REG_PATTERN_LEN:
          cfg_q.pattern_length <= cfg_i.data[ulrs_pkg::PLEN_W-1:0];
        ulrs_pkg::REG_FIRST_UNIT:  cfg_q.first_unit  <= cfg_i.data;
        ulrs_pkg::REG_SECOND_UNIT: cfg_q.second_unit <= cfg_i.data;
        ulrs_pkg::REG_NEW_UNIT:    cfg_q.new_unit    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  ulrs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg_q),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (push_job)
  );

  ulrs_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .head_job_o (head_job),
    .empty_o    (q_empty)
  );

  ulrs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_i     (head_job),
    .q_empty_i (q_empty),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

@@ src/ulrs_fifo.sv @@
// ulrs_fifo: short job queue that decouples the classifying front end from
// the result back end. Depends on ulrs_pkg.
`timescale 1ns / 1ps

module ulrs_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ulrs_pkg::job_t push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output ulrs_pkg::job_t head_job_o,
  output logic           empty_o
);

  ulrs_pkg::job_t                        mem_q [ulrs_pkg::FIFO_DEPTH];
  logic [ulrs_pkg::FIFO_PTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [ulrs_pkg::FIFO_PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [ulrs_pkg::FIFO_CNT_W-1:0]       cnt_q, cnt_d;
  logic                                  do_push, do_pop;

  assign full_o     = (cnt_q == ulrs_pkg::FIFO_CNT_W'(ulrs_pkg::FIFO_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign head_job_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  // Pointer wrap and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == ulrs_pkg::FIFO_PTR_W'(ulrs_pkg::FIFO_DEPTH - 1)) ?
                 '0 : wr_ptr_q + ulrs_pkg::FIFO_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == ulrs_pkg::FIFO_PTR_W'(ulrs_pkg::FIFO_DEPTH - 1)) ?
                 '0 : rd_ptr_q + ulrs_pkg::FIFO_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + ulrs_pkg::FIFO_CNT_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - ulrs_pkg::FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

@@ src/ulrs_front.sv @@
// ulrs_front: accepts input words, tracks a pending first pattern unit and
// classifies each word into a job for the back end. Depends on ulrs_pkg,
// ulrs_intf.
`timescale 1ns / 1ps

module ulrs_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  ulrs_in_if.sink        in_i,
  input  ulrs_pkg::cfg_t cfg_i,
  input  logic           q_full_i,
  output logic           push_o,
  output ulrs_pkg::job_t job_o
);

  logic                        pending_q, pending_d;
  logic                        accept;
  logic                        pair_mode, single_mode, strip_mode;
  logic                        is_ctrl;
  logic [ulrs_pkg::UNIT_W-1:0] u;

  assign u           = in_i.unit_in;
  assign in_i.ready  = !q_full_i;
  assign accept      = in_i.valid && !q_full_i;
  assign pair_mode   = (cfg_i.mode == ulrs_pkg::MODE_LITERAL) &&
                       (cfg_i.pattern_length == ulrs_pkg::PLEN_TWO);
  assign single_mode = (cfg_i.mode == ulrs_pkg::MODE_LITERAL) &&
                       (cfg_i.pattern_length == ulrs_pkg::PLEN_ONE);
  assign strip_mode  = (cfg_i.mode == ulrs_pkg::MODE_STRIP);
  assign is_ctrl     = (u == ulrs_pkg::UNIT_NUL) || (u == ulrs_pkg::UNIT_CR) ||
                       (u == ulrs_pkg::UNIT_LF)  || (u == ulrs_pkg::UNIT_TAB);

  // Classify the incoming unit
  always_comb begin
    pending_d        = pending_q;
    job_o.flush_unit = cfg_i.first_unit;
    job_o.flush_vld  = 1'b0;
    job_o.main_unit  = u;
    job_o.main_vld   = 1'b0;
    job_o.last       = in_i.last_in;

    if (pending_q && pair_mode && (u == cfg_i.second_unit)) begin
      // pair completes: one replacement unit
      pending_d        = 1'b0;
      job_o.flush_unit = cfg_i.new_unit;
      job_o.flush_vld  = 1'b1;
    end else begin
      // any held first unit goes out unchanged, then the unit is fresh
      job_o.flush_vld = pending_q;
      pending_d       = 1'b0;
      if (single_mode) begin
        job_o.main_vld  = 1'b1;
        job_o.main_unit = (u == cfg_i.first_unit) ? cfg_i.new_unit : u;
      end else if (pair_mode) begin
        if ((u == cfg_i.first_unit) && !in_i.last_in) begin
          pending_d = 1'b1;
        end else begin
          job_o.main_vld = 1'b1;
        end
      end else if (strip_mode) begin
        job_o.main_vld = !is_ctrl;
      end else begin
        job_o.main_vld = 1'b1;
      end
    end

    if (in_i.last_in) begin
      pending_d = 1'b0;
    end
  end

  assign push_o = accept && (job_o.flush_vld || job_o.main_vld || job_o.last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
    end else if (accept) begin
      pending_q <= pending_d;
    end
  end

endmodule

@@ src/ulrs_back.sv @@
// ulrs_back: emits one result word per unstalled cycle from queued jobs,
// with the running kept-unit count. Depends on ulrs_pkg, ulrs_intf.
`timescale 1ns / 1ps

module ulrs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ulrs_pkg::job_t job_i,
  input  logic           q_empty_i,
  output logic           pop_o,
  ulrs_out_if.source     out_o
);

  logic                         second_q, second_d;
  logic [ulrs_pkg::COUNT_W-1:0] cnt_q, cnt_d, cnt_inc;
  logic                         load;
  logic                         emit_flush;
  logic [ulrs_pkg::UNIT_W-1:0]  res_unit;
  logic                         res_vld, res_last;

  logic                         ovld_q;
  logic [ulrs_pkg::UNIT_W-1:0]  ounit_q;
  logic                         ouvld_q, olast_q;
  logic [ulrs_pkg::COUNT_W-1:0] okept_q, okept_d;

  // Output register takes a new word when empty or being drained
  assign load       = !q_empty_i && (!ovld_q || out_o.ready);
  assign emit_flush = job_i.flush_vld && !second_q;
  assign cnt_inc    = (cnt_q == ulrs_pkg::COUNT_MAX) ? cnt_q :
                      cnt_q + ulrs_pkg::COUNT_W'(1);

  // Pick this cycle's result from the head job
  always_comb begin
    second_d = second_q;
    pop_o    = 1'b0;
    if (emit_flush) begin
      res_unit = job_i.flush_unit;
      res_vld  = 1'b1;
      res_last = job_i.last && !job_i.main_vld;
    end else begin
      // main unit, or an empty end marker
      res_unit = job_i.main_vld ? job_i.main_unit : '0;
      res_vld  = job_i.main_vld;
      res_last = job_i.last;
    end
    if (load) begin
      if (emit_flush && job_i.main_vld) begin
        second_d = 1'b1;
      end else begin
        second_d = 1'b0;
        pop_o    = 1'b1;
      end
    end
  end

  // Kept-unit count
  always_comb begin
    okept_d = res_vld ? cnt_inc : cnt_q;
    cnt_d   = cnt_q;
    if (load) begin
      cnt_d = res_last ? '0 : okept_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q <= 1'b0;
      cnt_q    <= '0;
      ovld_q   <= 1'b0;
    end else begin
      second_q <= second_d;
      cnt_q    <= cnt_d;
      if (load) begin
        ovld_q <= 1'b1;
      end else if (out_o.ready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      ounit_q <= res_unit;
      ouvld_q <= res_vld;
      olast_q <= res_last;
      okept_q <= okept_d;
    end
  end

  assign out_o.valid      = ovld_q;
  assign out_o.unit_out   = ounit_q;
  assign out_o.unit_valid = ouvld_q;
  assign out_o.last_out   = olast_q;
  assign out_o.kept_count = okept_q;

endmodule

@@ test/tb_utf16_literal_replace_or_strip_core.sv @@
// Self-checking testbench for utf16_literal_replace_or_strip_core: directed
// strings, then random config phases. Depends on ulrs_pkg, ulrs_intf and the core.
`timescale 1ns / 1ps

module tb_utf16_literal_replace_or_strip_core;
  import ulrs_pkg::*;

  localparam logic [CIDX_W-1:0] REG_UNMAPPED = '1;

  // One output word as seen on out_o
  typedef struct packed {
    logic [UNIT_W-1:0]  unit;
    logic               present;
    logic               last;
    logic [COUNT_W-1:0] kept;
  } word_t;

  // Tracks register copies, the held first unit and the kept count, and
  // queues the words the core must emit.
  class replace_scoreboard;
    cfg_t               regs;
    logic               held;
    logic [COUNT_W-1:0] kept;
    word_t              words_due[$];
    int unsigned        errors;

    function new();
      regs.mode           = '0;
      regs.pattern_length = PLEN_ONE;
      regs.first_unit     = '0;
      regs.second_unit    = '0;
      regs.new_unit       = '0;
      held                = 1'b0;
      kept                = '0;
      errors              = 0;
    endfunction

    function void apply_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
      case (idx)
        REG_MODE:        regs.mode = data[MODE_W-1:0];
        REG_PATTERN_LEN: regs.pattern_length = data[PLEN_W-1:0];
        REG_FIRST_UNIT:  regs.first_unit = data[UNIT_W-1:0];
        REG_SECOND_UNIT: regs.second_unit = data[UNIT_W-1:0];
        REG_NEW_UNIT:    regs.new_unit = data[UNIT_W-1:0];
        default: ;
      endcase
    endfunction

    function void push_word(logic [UNIT_W-1:0] u, logic present);
      word_t w;
      if (present && kept != COUNT_MAX) kept = kept + 1'b1;
      w.unit    = present ? u : '0;
      w.present = present;
      w.last    = 1'b0;
      w.kept    = kept;
      words_due = {words_due, w};
    endfunction

    // Expected words for one accepted input word
    function void take_unit(logic [UNIT_W-1:0] u, logic l);
      int   base;
      logic pair_mode;
      logic paired;
      base      = words_due.size();
      pair_mode = (regs.mode == MODE_LITERAL) && (regs.pattern_length == PLEN_TWO);
      paired    = 1'b0;
      // held first unit: completes the pair or gets flushed as is
      if (held) begin
        held = 1'b0;
        if (pair_mode && u == regs.second_unit) begin
          push_word(regs.new_unit, 1'b1);
          paired = 1'b1;
        end else begin
          push_word(regs.first_unit, 1'b1);
        end
      end
      if (!paired) begin
        if (regs.mode == MODE_LITERAL && regs.pattern_length == PLEN_ONE) begin
          push_word((u == regs.first_unit) ? regs.new_unit : u, 1'b1);
        end else if (pair_mode) begin
          if (u == regs.first_unit && !l) held = 1'b1;
          else push_word(u, 1'b1);
        end else if (regs.mode == MODE_STRIP) begin
          if (!(u inside {UNIT_NUL, UNIT_CR, UNIT_LF, UNIT_TAB})) push_word(u, 1'b1);
        end else begin
          push_word(u, 1'b1);
        end
      end
      // end of string: empty marker if nothing came out, then clear state
      if (l) begin
        if (words_due.size() == base) push_word('0, 1'b0);
        words_due[words_due.size()-1].last = 1'b1;
        held = 1'b0;
        kept = '0;
      end
    endfunction

    function void match_word(word_t got);
      word_t exp;
      if (words_due.size() == 0) begin
        $error("unexpected word: unit_out %h unit_valid %b last_out %b kept_count %0d",
               got.unit, got.present, got.last, got.kept);
        errors++;
        return;
      end
      exp = words_due.pop_front();
      if (got.unit !== exp.unit) begin
        $error("unit_out: expected %h, got %h", exp.unit, got.unit);
        errors++;
      end
      if (got.present !== exp.present) begin
        $error("unit_valid: expected %b, got %b", exp.present, got.present);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last_out: expected %b, got %b", exp.last, got.last);
        errors++;
      end
      if (got.kept !== exp.kept) begin
        $error("kept_count: expected %0d, got %0d", exp.kept, got.kept);
        errors++;
      end
    endfunction

    function int words_left();
      return words_due.size();
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ulrs_in_if  in_if ();
  ulrs_out_if out_if ();
  ulrs_cfg_if cfg_if ();

  replace_scoreboard sb = new();

  bit          quiet      = 1'b0;
  bit          hold_req   = 1'b0;
  int unsigned gap_odds   = 4;
  int unsigned stall_odds = 4;

  utf16_literal_replace_or_strip_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Monitors: accepted input words, output words, register writes
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) sb.take_unit(in_if.unit_in, in_if.last_in);
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.match_word('{out_if.unit_out, out_if.unit_valid, out_if.last_out, out_if.kept_count});
  end

  always @(posedge clk) begin
    if (rst_n && cfg_if.valid && cfg_if.ready) sb.apply_reg(cfg_if.index, cfg_if.data);
  end

  // Output side: random stall bursts, one long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (120) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_unit(input logic [UNIT_W-1:0] u, input logic l);
    in_if.valid   <= 1'b1;
    in_if.unit_in <= u;
    in_if.last_in <= l;
    do @(posedge clk); while (!in_if.ready);
    if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering, wait for every due word, then let the pipeline settle
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.words_left() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [UNIT_W-1:0] control_unit();
    case ($urandom_range(0, 3))
      0:       return UNIT_NUL;
      1:       return UNIT_CR;
      2:       return UNIT_LF;
      default: return UNIT_TAB;
    endcase
  endfunction

  function automatic logic [UNIT_W-1:0] pick_pattern_unit();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2:       return '1;
      3:       return control_unit();
      default: return UNIT_W'($urandom);
    endcase
  endfunction

  // New register settings for a phase, biased toward the replacing modes
  task automatic random_config();
    logic [MODE_W-1:0] mode_val;
    logic [PLEN_W-1:0] plen_val;
    logic [UNIT_W-1:0] first_val;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: mode_val = MODE_LITERAL;
      5, 6:          mode_val = MODE_STRIP;
      7:             mode_val = '0;
      8:             mode_val = '1;
      default:       mode_val = MODE_W'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: plen_val = PLEN_TWO;
      5, 6:          plen_val = PLEN_ONE;
      7:             plen_val = '0;
      8:             plen_val = '1;
      default:       plen_val = PLEN_W'($urandom);
    endcase
    first_val = pick_pattern_unit();
    // upper data bits are don't-care for the 8-bit registers
    if ($urandom_range(0, 3) != 0) write_reg(REG_MODE, {8'($urandom), mode_val});
    if ($urandom_range(0, 3) != 0) write_reg(REG_PATTERN_LEN, {8'($urandom), plen_val});
    if ($urandom_range(0, 3) != 0) write_reg(REG_FIRST_UNIT, first_val);
    if ($urandom_range(0, 3) != 0)
      write_reg(REG_SECOND_UNIT, ($urandom_range(0, 4) == 0) ? sb.regs.first_unit
                                                               : pick_pattern_unit());
    if ($urandom_range(0, 3) != 0) write_reg(REG_NEW_UNIT, pick_pattern_unit());
    if ($urandom_range(0, 15) == 0) write_reg(REG_UNMAPPED, CDATA_W'($urandom));
  endtask

  initial begin
    int                phase;
    int                k;
    int                r;
    logic [UNIT_W-1:0] u;
    logic [UNIT_W-1:0] carry;
    bit                have_carry;
    logic              l;

    in_if.valid   <= 1'b0;
    in_if.unit_in <= '0;
    in_if.last_in <= 1'b0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= '0;
    cfg_if.data   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pass-through after reset
    send_unit(16'hFFFF, 1'b0);
    send_unit(16'h0000, 1'b1);

    // single-unit replace
    wait_idle();
    write_reg(REG_MODE, MODE_LITERAL);
    write_reg(REG_FIRST_UNIT, 16'hFFFF);
    write_reg(REG_NEW_UNIT, 16'h0000);
    send_unit(16'hFFFF, 1'b0);
    send_unit(16'h1234, 1'b0);
    send_unit(16'hFFFF, 1'b1);

    // pair replace: hit, mismatch after held unit, flush then pair,
    // held unit broken by the last unit
    wait_idle();
    write_reg(REG_PATTERN_LEN, PLEN_TWO);
    write_reg(REG_FIRST_UNIT, 16'h0041);
    write_reg(REG_SECOND_UNIT, 16'h0042);
    write_reg(REG_NEW_UNIT, 16'hFFFF);
    send_unit(16'h0041, 1'b0);
    send_unit(16'h0042, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'h0043, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'h0042, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'h0044, 1'b1);

    // first equal to second: greedy pairing, first unit as the last unit
    wait_idle();
    write_reg(REG_FIRST_UNIT, 16'h0030);
    write_reg(REG_SECOND_UNIT, 16'h0030);
    send_unit(16'h0030, 1'b0);
    send_unit(16'h0030, 1'b0);
    send_unit(16'h0030, 1'b1);

    // leave pair mode while a first unit is held
    send_unit(16'h0030, 1'b0);
    wait_idle();
    write_reg(REG_MODE, '0);
    write_reg(REG_UNMAPPED, 16'hFFFF);
    send_unit(16'h0045, 1'b1);

    // strip mode: all-control string gives only the empty marker
    wait_idle();
    write_reg(REG_MODE, MODE_STRIP);
    send_unit(UNIT_NUL, 1'b0);
    send_unit(UNIT_CR, 1'b0);
    send_unit(UNIT_LF, 1'b0);
    send_unit(UNIT_TAB, 1'b1);
    send_unit(16'h0020, 1'b1);

    // random phases; strings may cross phase boundaries
    for (phase = 0; phase < 22; phase++) begin
      wait_idle();
      quiet = (phase >= 19);
      gap_odds   = $urandom_range(0, 3) * 3;
      stall_odds = $urandom_range(0, 3) * 3;
      random_config();
      if (phase == 4) hold_req = 1'b1;
      have_carry = 1'b0;
      for (k = 0; k < 83; k++) begin
        if (phase == 8 && k == 40) wait_idle();
        if (have_carry) begin
          u          = carry;
          have_carry = 1'b0;
        end else begin
          r = $urandom_range(0, 9);
          case (r)
            0, 1, 2, 3: begin
              u = sb.regs.first_unit;
              if ($urandom_range(0, 3) != 0) begin
                carry      = sb.regs.second_unit;
                have_carry = 1'b1;
              end
            end
            4:       u = sb.regs.second_unit;
            5:       u = sb.regs.new_unit;
            6:       u = control_unit();
            default: u = UNIT_W'($urandom);
          endcase
        end
        l = ($urandom_range(0, 7) == 0);
        send_unit(u, l);
      end
    end

    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.words_left() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_utf16_literal_replace_or_strip_core: PASS");
    end else begin
      $display("tb_utf16_literal_replace_or_strip_core: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("tb_utf16_literal_replace_or_strip_core: FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
src/ulrs_pkg.sv
src/ulrs_intf.sv
src/ulrs_fifo.sv
src/ulrs_front.sv
src/ulrs_back.sv
src/utf16_literal_replace_or_strip_core.sv
test/tb_utf16_literal_replace_or_strip_core.sv
